### rtl/mbet_pkg.sv
// Package for the Mandelbrot escape-time block: payload structs, register
// indexes, fixed field widths and default parameter values.
// No dependencies; mandelbrot_escape_time imports it.
package mbet_pkg;

  localparam int FRAC_BITS_DEF  = 28;
  localparam int COORD_BITS_DEF = 32;

  // Row and column fields are fixed at this width.
  localparam int PIXEL_INDEX_BITS = 10;

  localparam int EDGE_W  = 32;
  localparam int STEP_W  = 31;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Escape bounds: |z|^2 against ESCAPE_NORM, a single part against ESCAPE_PART.
  localparam int ESCAPE_NORM = 4;
  localparam int ESCAPE_PART = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

  // Register reset values.
  localparam logic signed [EDGE_W-1:0] LEFT_EDGE_RST  = -32'sd778772865;
  localparam logic signed [EDGE_W-1:0] TOP_EDGE_RST   = 32'sd301989888;
  localparam logic [STEP_W-1:0]        STEP_REAL_RST  = 31'd1258291;
  localparam logic [STEP_W-1:0]        STEP_IMAG_RST  = 31'd1258291;
  localparam logic [COUNT_W-1:0]       ITER_LIMIT_RST = 16'd15000;

  typedef struct packed {
    logic [PIXEL_INDEX_BITS-1:0] pixel_row;
    logic [PIXEL_INDEX_BITS-1:0] pixel_col;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iteration_count;
    logic               escaped;
  } out_t;

endpackage

### rtl/mandelbrot_escape_time.sv
// Channel   Ports                                   Direction  Flow
// request   start, busy, in_data                    in         start taken when busy is low
// result    out_valid, out_data                     out        one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in      valid and ready; ready when idle
//
// A request first forms point c through the shared multiplier, then runs each iteration as
// x^2, y^2, test and x*y, update; the single registered multiplier sets these steps. It ends
// in the x^2 step when a part of z exceeds 2, or in the test step when the magnitude test
// or the limit stops it. The result strobe comes in the cycle after, with busy already low.
// Reset (rst_n low, synchronous) loads the register defaults and idles the sequencer.
// Depends on mbet_pkg and mbet_mul.
module mandelbrot_escape_time #(
  parameter int FRAC_BITS  = mbet_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  mbet_pkg::in_t                       in_data,
  output logic                                out_valid,
  output mbet_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbet_pkg::*;

  localparam int MAG_W   = FRAC_BITS + 2;
  localparam int MUL_W   = (MAG_W > STEP_W) ? MAG_W : STEP_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int CP_W    = PIXEL_INDEX_BITS + STEP_W;
  localparam int TERM_W  = FRAC_BITS + 6;
  localparam int CSUM_W  = ((COORD_BITS > CP_W + 1) ? COORD_BITS : CP_W + 1) + 1;
  localparam int ADD_W   = ((COORD_BITS > TERM_W) ? COORD_BITS : TERM_W) + 1;
  localparam int SAT_W   = (CSUM_W > ADD_W) ? CSUM_W : ADD_W;

  localparam logic [COORD_BITS-1:0] BOUND = COORD_BITS'(ESCAPE_PART) << FRAC_BITS;
  localparam logic [SQ_W:0] THR = (SQ_W + 1)'(ESCAPE_NORM / 4) << (2 * FRAC_BITS + 2);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MRE  = 3'd1;
  localparam logic [2:0] ST_MIM  = 3'd2;
  localparam logic [2:0] ST_CIM  = 3'd3;
  localparam logic [2:0] ST_SQX  = 3'd4;
  localparam logic [2:0] ST_SQY  = 3'd5;
  localparam logic [2:0] ST_CHK  = 3'd6;
  localparam logic [2:0] ST_UPD  = 3'd7;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SAT_W-1:0] v
  );
    logic [SAT_W-COORD_BITS:0] hi;
    hi = v[SAT_W-1:COORD_BITS-1];
    if ((&hi) || !(|hi)) return v[COORD_BITS-1:0];
    return {v[SAT_W-1], {(COORD_BITS-1){~v[SAT_W-1]}}};
  endfunction

  logic signed [EDGE_W-1:0]     left_edge_r, top_edge_r;
  logic [STEP_W-1:0]            step_real_r, step_imag_r;
  logic [COUNT_W-1:0]           iter_limit_r;

  logic [2:0]                   state_r;
  logic [PIXEL_INDEX_BITS-1:0]  row_r, col_r;
  logic signed [COORD_BITS-1:0] c_re_r, c_im_r, x_r, y_r;
  logic [COUNT_W-1:0]           n_r;
  logic [SQ_W-1:0]              x2_r;
  logic signed [SQ_W:0]         diff_r;
  logic                         neg_r;
  logic                         out_valid_r;
  out_t                         out_data_r;

  logic [MUL_W-1:0]             op_a, op_b;
  logic [2*MUL_W-1:0]           prod_r;

  logic [COORD_BITS-1:0]        mx, my;
  logic                         big_part;
  logic [SQ_W-1:0]              prod_sq;
  logic [SQ_W:0]                sq_sum;
  logic signed [CSUM_W-1:0]     left_ext, top_ext, cp_ext;
  logic signed [SQ_W+1:0]       two_p;
  logic signed [TERM_W-1:0]     term_x, term_y;
  logic signed [SAT_W-1:0]      x_sum, y_sum;

  mbet_mul #(.OP_W(MUL_W)) u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign mx       = x_r[COORD_BITS-1] ? COORD_BITS'(-x_r) : COORD_BITS'(x_r);
  assign my       = y_r[COORD_BITS-1] ? COORD_BITS'(-y_r) : COORD_BITS'(y_r);
  assign big_part = (mx > BOUND) || (my > BOUND);
  assign prod_sq  = prod_r[SQ_W-1:0];
  assign sq_sum   = {1'b0, x2_r} + {1'b0, prod_sq};

  assign left_ext = CSUM_W'(left_edge_r);
  assign top_ext  = CSUM_W'(top_edge_r);
  assign cp_ext   = CSUM_W'(prod_r[CP_W-1:0]);

  // New z: both terms are floor-shifted before c is added, as an arithmetic shift does.
  assign two_p  = neg_r ? -$signed({1'b0, prod_sq, 1'b0}) : $signed({1'b0, prod_sq, 1'b0});
  assign term_x = TERM_W'(diff_r >>> FRAC_BITS);
  assign term_y = TERM_W'(two_p >>> FRAC_BITS);
  assign x_sum  = SAT_W'(term_x) + SAT_W'(c_re_r);
  assign y_sum  = SAT_W'(term_y) + SAT_W'(c_im_r);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_MRE: begin
        op_a = MUL_W'(col_r);
        op_b = MUL_W'(step_real_r);
      end
      ST_MIM: begin
        op_a = MUL_W'(row_r);
        op_b = MUL_W'(step_imag_r);
      end
      ST_SQX: begin
        op_a = MUL_W'(MAG_W'(mx));
        op_b = MUL_W'(MAG_W'(mx));
      end
      ST_SQY: begin
        op_a = MUL_W'(MAG_W'(my));
        op_b = MUL_W'(MAG_W'(my));
      end
      ST_CHK: begin
        op_a = MUL_W'(MAG_W'(mx));
        op_b = MUL_W'(MAG_W'(my));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_edge_r  <= LEFT_EDGE_RST;
      top_edge_r   <= TOP_EDGE_RST;
      step_real_r  <= STEP_REAL_RST;
      step_imag_r  <= STEP_IMAG_RST;
      iter_limit_r <= ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT_EDGE:  left_edge_r  <= cfg_data;
        REG_TOP_EDGE:   top_edge_r   <= cfg_data;
        REG_STEP_REAL:  step_real_r  <= cfg_data[STEP_W-1:0];
        REG_STEP_IMAG:  step_imag_r  <= cfg_data[STEP_W-1:0];
        REG_ITER_LIMIT: iter_limit_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) state_r <= ST_MRE;
        end
        ST_MRE: state_r <= ST_MIM;
        ST_MIM: state_r <= ST_CIM;
        ST_CIM: state_r <= ST_SQX;
        ST_SQX: begin
          if (big_part) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= ST_SQY;
          end
        end
        ST_SQY: state_r <= ST_CHK;
        ST_CHK: begin
          if ((sq_sum > THR) || (n_r >= iter_limit_r)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: state_r <= ST_SQX;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        row_r <= in_data.pixel_row;
        col_r <= in_data.pixel_col;
        x_r   <= '0;
        y_r   <= '0;
        n_r   <= '0;
      end
      ST_MIM: c_re_r <= sat_coord(SAT_W'(left_ext + cp_ext));
      ST_CIM: c_im_r <= sat_coord(SAT_W'(top_ext - cp_ext));
      ST_SQX: begin
        out_data_r.iteration_count <= n_r;
        out_data_r.escaped         <= 1'b1;
      end
      ST_SQY: x2_r <= prod_sq;
      ST_CHK: begin
        out_data_r.iteration_count <= n_r;
        out_data_r.escaped         <= sq_sum > THR;
        diff_r <= $signed({1'b0, x2_r}) - $signed({1'b0, prod_sq});
        neg_r  <= x_r[COORD_BITS-1] ^ y_r[COORD_BITS-1];
      end
      ST_UPD: begin
        x_r <= sat_coord(x_sum);
        y_r <= sat_coord(y_sum);
        n_r <= n_r + COUNT_W'(1);
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  // Registers change only between requests.
  assign cfg_ready = ~busy;

endmodule

### rtl/mbet_mul.sv
// Shared unsigned multiplier for the escape-time block, product registered.
// Depends on nothing but its parameter; instanced by mandelbrot_escape_time.
module mbet_mul #(
  parameter int OP_W = 31
) (
  input  logic              clk,
  input  logic [OP_W-1:0]   op_a,
  input  logic [OP_W-1:0]   op_b,
  output logic [2*OP_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

### tb/sv/mandelbrot_escape_time_tb.sv
// Self-checking testbench for mandelbrot_escape_time: directed corner cases,
// then random views, each result checked against an escape-time predictor.
// Depends on mbet_pkg and the RTL of the block.
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
  import mbet_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS_DEF - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint PART_Q    = longint'(ESCAPE_PART) <<< FRAC_BITS_DEF;
  localparam longint NORM_Q    = longint'(ESCAPE_NORM) <<< (2 * FRAC_BITS_DEF);
  localparam longint Q_ONE     = longint'(1) <<< FRAC_BITS_DEF;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the register file.
  logic signed [EDGE_W-1:0] view_left  = LEFT_EDGE_RST;
  logic signed [EDGE_W-1:0] view_top   = TOP_EDGE_RST;
  logic [STEP_W-1:0]        step_re    = STEP_REAL_RST;
  logic [STEP_W-1:0]        step_im    = STEP_IMAG_RST;
  logic [COUNT_W-1:0]       iter_limit = ITER_LIMIT_RST;

  out_t        escape_results[$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;

  mandelbrot_escape_time i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Runs z = z*z + c for one pixel under the current register values.
  function automatic out_t iterate_point(input in_t px);
    longint c_re, c_im, x, y, x_sq, y_sq, x_next;
    int     n;
    bit     esc, done;
    out_t   res;
    c_re = clamp_coord(longint'(view_left) + longint'(px.pixel_col) * longint'(step_re));
    c_im = clamp_coord(longint'(view_top) - longint'(px.pixel_row) * longint'(step_im));
    x = 0;
    y = 0;
    x_sq = 0;
    y_sq = 0;
    n = 0;
    esc = 1'b0;
    done = 1'b0;
    while (!done) begin
      // A single part beyond two settles the test without the squares.
      if (x > PART_Q || -x > PART_Q || y > PART_Q || -y > PART_Q) begin
        esc = 1'b1;
      end else begin
        x_sq = x * x;
        y_sq = y * y;
        esc = (x_sq + y_sq > NORM_Q);
      end
      if (esc || n >= int'(iter_limit)) begin
        done = 1'b1;
      end else begin
        // Arithmetic shifts give the floor rounding that the block uses.
        x_next = clamp_coord(((x_sq - y_sq) >>> FRAC_BITS_DEF) + c_re);
        y = clamp_coord(((2 * x * y) >>> FRAC_BITS_DEF) + c_im);
        x = x_next;
        n++;
      end
    end
    res.iteration_count = COUNT_W'(n);
    res.escaped = esc;
    return res;
  endfunction

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LEFT_EDGE:  view_left  = data;
      REG_TOP_EDGE:   view_top   = data;
      REG_STEP_REAL:  step_re    = data[STEP_W-1:0];
      REG_STEP_IMAG:  step_im    = data[STEP_W-1:0];
      REG_ITER_LIMIT: iter_limit = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] left, top, s_re, s_im, limit);
    write_reg(REG_LEFT_EDGE, left);
    write_reg(REG_TOP_EDGE, top);
    write_reg(REG_STEP_REAL, s_re);
    write_reg(REG_STEP_IMAG, s_im);
    write_reg(REG_ITER_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Start stays high between back-to-back requests; it drops for a gap or in settle.
  task automatic send_pixel(input int row, input int col);
    in_t px;
    px.pixel_row = PIXEL_INDEX_BITS'(row);
    px.pixel_col = PIXEL_INDEX_BITS'(col);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    escape_results.push_back(iterate_point(px));
  endtask

  task automatic settle();
    start <= 1'b0;
    while (escape_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_view();
    send_pixel(0, 0);
    send_pixel(0, 1023);
    send_pixel(1023, 0);
    send_pixel(1023, 1023);
    // On the real axis near -0.2, inside the set: runs to the full default limit.
    send_pixel(240, 576);
    settle();
  endtask

  task automatic test_coord_saturation();
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd8);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    settle();
    // Bit 31 of the step data must be dropped by the register.
    load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'd8);
    send_pixel(0, 1023);
    send_pixel(1023, 0);
    settle();
  endtask

  // Grid of half steps from -2 along the real axis, downwards from 0 in imaginary.
  task automatic test_escape_cases();
    write_reg(REG_UNMAPPED, $urandom());
    load_config(32'(-2 * Q_ONE), 32'd0, 32'(Q_ONE / 2), 32'(Q_ONE / 2), 32'd20);
    send_pixel(0, 0);       // c = -2: |z| stays exactly 2, never escapes
    send_pixel(0, 4);       // c = 0
    send_pixel(0, 8);       // c = 2: on the circle first, outside next
    send_pixel(0, 10);      // c = 3: real part beyond two
    send_pixel(3, 7);       // c = 1.5 - 1.5i: both parts small, sum too big
    send_pixel(4, 4);       // c = -2i
    send_pixel(1, 3);
    send_pixel(2, 5);
    send_pixel(1023, 1023); // both parts of c saturate
    settle();
  endtask

  task automatic test_limit_corners();
    load_config(32'(-2 * Q_ONE), 32'd0, 32'(Q_ONE / 2), 32'(Q_ONE / 2), 32'd0);
    send_pixel(0, 4);
    send_pixel(0, 10);
    settle();
    load_config(32'(-2 * Q_ONE), 32'd0, 32'(Q_ONE / 2), 32'(Q_ONE / 2), 32'd1);
    send_pixel(0, 10);      // outside exactly when the limit is hit
    send_pixel(0, 4);
    send_pixel(0, 8);
    settle();
    load_config(32'(-2 * Q_ONE), 32'd0, 32'(Q_ONE / 2), 32'(Q_ONE / 2), 32'd2);
    send_pixel(0, 8);
    settle();
  endtask

  task automatic test_limit_max();
    load_config(32'(-2 * Q_ONE), 32'd0, 32'(Q_ONE / 2), 32'(Q_ONE / 2), 32'hFFFF_FFFF);
    send_pixel(0, 4);
    send_pixel(2, 5);
    settle();
  endtask

  // Mostly views over the interesting region with short limits; now and then a view
  // with every edge and step bit random. The last phases run without gaps.
  task automatic test_random_views(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      idle_on = (p < phases - 2);
      if ($urandom_range(0, 4) == 0) begin
        load_config($urandom(), $urandom(), $urandom(), $urandom(),
                    {16'($urandom()), 16'($urandom_range(1, 40))});
      end else begin
        load_config(32'(longint'(-5 * Q_ONE / 2) + longint'($urandom_range(0, 3 * Q_ONE))),
                    32'(longint'(-3 * Q_ONE / 2) + longint'($urandom_range(0, 3 * Q_ONE))),
                    $urandom_range(1 << 14, 1 << 21), $urandom_range(1 << 14, 1 << 21),
                    $urandom_range(1, 40));
      end
      for (int i = 0; i < per_phase; i++) send_pixel($urandom_range(0, 1023),
                                                     $urandom_range(0, 1023));
      settle();
    end
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid) begin
      if (escape_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual count %0d escaped %0b",
                 $time, out_data.iteration_count, out_data.escaped);
      end else begin
        want = escape_results.pop_front();
        if (out_data.iteration_count !== want.iteration_count) begin
          errors++;
          $display("%0t: iteration_count expected %0d, actual %0d",
                   $time, want.iteration_count, out_data.iteration_count);
        end
        if (out_data.escaped !== want.escaped) begin
          errors++;
          $display("%0t: escaped expected %0b, actual %0b",
                   $time, want.escaped, out_data.escaped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, escape_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_view();
    test_coord_saturation();
    test_escape_cases();
    test_limit_corners();
    test_limit_max();
    test_random_views(8, 9);

    if (errors == 0 && escape_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mbet_pkg.sv
rtl/mbet_mul.sv
rtl/mandelbrot_escape_time.sv
tb/sv/mandelbrot_escape_time_tb.sv
